FILE: design/tbsm_pkg.sv
// shared types, constants and functions of the tdm basic slot monitor
package tbsm_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_ID        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CS_ERROR_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_WINDOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_TIMEOUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TB_DISABLE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TB_HOLD_TIME   = 3'd7;

  localparam logic [15:0] RST_LIMIT          = 16'd20000;
  localparam logic [15:0] RST_RATE_WINDOW    = 16'd53333;
  localparam logic [15:0] RST_TOGGLE_TIMEOUT = 16'd320;
  localparam logic [15:0] RST_TB_DISABLE     = 16'd100;
  localparam logic [15:0] RST_TB_HOLD_TIME   = 16'd10667;

  localparam logic [15:0] SAT_MAX = 16'hFFFF;

  localparam logic [3:0] PHASE_HEALTH = 4'd4;
  localparam logic [3:0] PHASE_LAST   = 4'd9;

  localparam int BIT_DST    = 4;
  localparam int BIT_TOGGLE = 5;
  localparam int BIT_WARN   = 6;
  localparam int BIT_ALARM  = 7;

  typedef struct packed {
    logic [3:0]  slot_id;
    logic [15:0] mismatch_limit;
    logic [15:0] cs_error_limit;
    logic [15:0] rate_limit;
    logic [15:0] rate_window;
    logic [15:0] toggle_timeout;
    logic [15:0] tb_disable_threshold;
    logic [15:0] tb_hold_time;
  } cfg_t;

  typedef struct packed {
    logic cs_ok;
    logic id_ok;
  } chk_t;

  typedef struct packed {
    logic        alarm_now;
    logic        toggle_now;
    logic        restart;
    logic        reset_req;
    logic        alarm;
    logic [15:0] rate;
  } stat_t;

  function automatic logic [3:0] check_nibble(input logic [15:0] w);
    check_nibble = 4'd1 + w[3:0] + w[7:4] + w[11:8];
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == SAT_MAX) ? SAT_MAX : v + 16'd1;
  endfunction

endpackage

FILE: design/tdm_basic_slot_monitor.sv
// top level: config registers, input word register, result word register
// an accepted word moves from the input word register to the result word register once that register is free
// throughput: one word per cycle while out_stall is low; the state update between the registers is combinational
// while a result waits under stall the input register takes one word, then in_stall rises
// reset: synchronous; config returns to defaults, counters, phases and flags clear,
// toggle watch enabled, alarm hold loaded with ALARM_HOLD
module tdm_basic_slot_monitor #(
  parameter logic [15:0] ALARM_HOLD = 16'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] rx_word,
  input  logic        tx_dst_bit,
  input  logic [3:0]  tx_rate_bits,
  input  logic        warning_active,
  input  logic        alarm_active,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] tx_word,
  output logic        checksum_ok,
  output logic        slot_ok,
  output logic        rx_dst_valid,
  output logic        rx_dst_bit,
  output logic        restart_flag,
  output logic        reset_request,
  output logic        bus_alarm,
  output logic [15:0] error_rate
);

  tbsm_pkg::cfg_t  cfg;
  tbsm_pkg::chk_t  chk;
  tbsm_pkg::stat_t stat;

  logic        in_full;
  logic [15:0] in_rx_word;
  logic        in_dst_bit;
  logic [3:0]  in_rate_bits;
  logic        in_warn;
  logic        in_alarm;
  logic        advance;
  logic        in_take;
  logic [15:0] tx_word_next;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_id              <= 4'd0;
      cfg.mismatch_limit       <= tbsm_pkg::RST_LIMIT;
      cfg.cs_error_limit       <= tbsm_pkg::RST_LIMIT;
      cfg.rate_limit           <= tbsm_pkg::RST_LIMIT;
      cfg.rate_window          <= tbsm_pkg::RST_RATE_WINDOW;
      cfg.toggle_timeout       <= tbsm_pkg::RST_TOGGLE_TIMEOUT;
      cfg.tb_disable_threshold <= tbsm_pkg::RST_TB_DISABLE;
      cfg.tb_hold_time         <= tbsm_pkg::RST_TB_HOLD_TIME;
    end else if (cfg_we) begin
      case (cfg_index)
        tbsm_pkg::CFG_SLOT_ID:        cfg.slot_id              <= cfg_data[3:0];
        tbsm_pkg::CFG_MISMATCH_LIMIT: cfg.mismatch_limit       <= cfg_data;
        tbsm_pkg::CFG_CS_ERROR_LIMIT: cfg.cs_error_limit       <= cfg_data;
        tbsm_pkg::CFG_RATE_LIMIT:     cfg.rate_limit           <= cfg_data;
        tbsm_pkg::CFG_RATE_WINDOW:    cfg.rate_window          <= cfg_data;
        tbsm_pkg::CFG_TOGGLE_TIMEOUT: cfg.toggle_timeout       <= cfg_data;
        tbsm_pkg::CFG_TB_DISABLE:     cfg.tb_disable_threshold <= cfg_data;
        tbsm_pkg::CFG_TB_HOLD_TIME:   cfg.tb_hold_time         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_rx_word   <= rx_word;
      in_dst_bit   <= tx_dst_bit;
      in_rate_bits <= tx_rate_bits;
      in_warn      <= warning_active;
      in_alarm     <= alarm_active;
    end
  end

  tbsm_check u_check (
    .rx_word        (in_rx_word),
    .tx_dst_bit     (in_dst_bit),
    .tx_rate_bits   (in_rate_bits),
    .warning_active (in_warn),
    .alarm_active   (in_alarm),
    .slot_id        (cfg.slot_id),
    .stat           (stat),
    .chk            (chk),
    .tx_word        (tx_word_next)
  );

  tbsm_sched #(
    .ALARM_HOLD (ALARM_HOLD)
  ) u_sched (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .rx_toggle_bit (in_rx_word[tbsm_pkg::BIT_TOGGLE]),
    .chk           (chk),
    .cfg           (cfg),
    .stat          (stat)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_word       <= tx_word_next;
      checksum_ok   <= chk.cs_ok;
      slot_ok       <= chk.id_ok;
      rx_dst_valid  <= chk.cs_ok & chk.id_ok;
      rx_dst_bit    <= in_rx_word[tbsm_pkg::BIT_DST];
      restart_flag  <= stat.restart;
      reset_request <= stat.reset_req;
      bus_alarm     <= stat.alarm;
      error_rate    <= stat.rate;
    end
  end

endmodule

FILE: design/tbsm_check.sv
// receive word checks and transmit word assembly
module tbsm_check (
  input  logic [15:0]           rx_word,
  input  logic                  tx_dst_bit,
  input  logic [3:0]            tx_rate_bits,
  input  logic                  warning_active,
  input  logic                  alarm_active,
  input  logic [3:0]            slot_id,
  input  tbsm_pkg::stat_t       stat,
  output tbsm_pkg::chk_t        chk,
  output logic [15:0]           tx_word
);

  logic [15:0] tx_base;

  always_comb begin
    chk.cs_ok = (tbsm_pkg::check_nibble(rx_word) == rx_word[15:12]);
    chk.id_ok = (rx_word[3:0] == slot_id);
  end

  always_comb begin
    tx_base = 16'd0;
    tx_base[3:0] = slot_id;
    tx_base[tbsm_pkg::BIT_DST] = tx_dst_bit;
    tx_base[tbsm_pkg::BIT_TOGGLE] = stat.toggle_now;
    tx_base[tbsm_pkg::BIT_WARN] = warning_active;
    tx_base[tbsm_pkg::BIT_ALARM] = alarm_active | stat.alarm_now;
    tx_base[11:8] = tx_rate_bits;
    tx_word = {tbsm_pkg::check_nibble(tx_base), tx_base[11:0]};
  end

endmodule

FILE: design/tbsm_sched.sv
// error counters, rate window, frame scheduler, health check and toggle watchdog
module tbsm_sched #(
  parameter logic [15:0] ALARM_HOLD = 16'd0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             rx_toggle_bit,
  input  tbsm_pkg::chk_t   chk,
  input  tbsm_pkg::cfg_t   cfg,
  output tbsm_pkg::stat_t  stat
);

  logic [15:0] cs_err_run, cs_err_run_next;
  logic [15:0] id_mismatch_run, id_mismatch_run_next;
  logic [15:0] window_timer, window_timer_next;
  logic [15:0] window_errors, window_errors_next;
  logic [15:0] rate_value, rate_value_next;
  logic [3:0]  fast_phase, fast_phase_next;
  logic [3:0]  slow_phase, slow_phase_next;
  logic        tb_enabled, tb_enabled_next;
  logic        tb_last, tb_last_next;
  logic [15:0] tb_still_count, tb_still_count_next;
  logic [15:0] tb_hold_count, tb_hold_count_next;
  logic        tx_toggle, tx_toggle_next;
  logic        restart_reg, restart_reg_next;
  logic        reset_req_reg, reset_req_reg_next;
  logic        alarm_reg, alarm_reg_next;
  logic [15:0] alarm_hold_count, alarm_hold_count_next;

  always_comb begin
    cs_err_run_next       = chk.cs_ok ? 16'd0 : tbsm_pkg::sat_inc(cs_err_run);
    id_mismatch_run_next  = chk.id_ok ? 16'd0 : tbsm_pkg::sat_inc(id_mismatch_run);
    window_errors_next    = chk.cs_ok ? window_errors : tbsm_pkg::sat_inc(window_errors);
    window_timer_next     = window_timer + 16'd1;
    rate_value_next       = rate_value;
    fast_phase_next       = fast_phase;
    slow_phase_next       = slow_phase;
    tb_enabled_next       = tb_enabled;
    tb_last_next          = tb_last;
    tb_still_count_next   = tb_still_count;
    tb_hold_count_next    = tb_hold_count;
    tx_toggle_next        = tx_toggle;
    restart_reg_next      = restart_reg;
    reset_req_reg_next    = reset_req_reg;
    alarm_reg_next        = alarm_reg;
    alarm_hold_count_next = alarm_hold_count;

    if (window_timer_next >= cfg.rate_window) begin
      rate_value_next    = window_errors_next;
      window_errors_next = 16'd0;
      window_timer_next  = 16'd0;
    end

    if (fast_phase == tbsm_pkg::PHASE_HEALTH) begin
      if (id_mismatch_run_next > cfg.mismatch_limit ||
          cs_err_run_next > cfg.cs_error_limit ||
          rate_value_next > cfg.rate_limit) begin
        restart_reg_next      = 1'b1;
        alarm_reg_next        = 1'b1;
        alarm_hold_count_next = ALARM_HOLD;
        tb_enabled_next       = 1'b0;
        tb_hold_count_next    = cfg.tb_hold_time;
      end
      if (alarm_hold_count_next != 16'd0) begin
        alarm_hold_count_next = alarm_hold_count_next - 16'd1;
      end else begin
        alarm_reg_next = 1'b0;
      end
      if (cs_err_run_next > cfg.tb_disable_threshold) begin
        tb_enabled_next    = 1'b0;
        tb_hold_count_next = cfg.tb_hold_time;
      end else if (tb_hold_count_next != 16'd0) begin
        tb_hold_count_next = tb_hold_count_next - 16'd1;
      end else begin
        tb_enabled_next = 1'b1;
      end
      fast_phase_next = tbsm_pkg::PHASE_HEALTH + 4'd1;
    end else if (fast_phase >= tbsm_pkg::PHASE_LAST) begin
      if (slow_phase == 4'd0) begin
        if (tb_enabled && (tb_last == rx_toggle_bit)) begin
          tb_still_count_next = tbsm_pkg::sat_inc(tb_still_count);
          if (tb_still_count_next > cfg.toggle_timeout) begin
            reset_req_reg_next = 1'b1;
          end
        end else begin
          tb_still_count_next = 16'd0;
        end
        tb_last_next   = rx_toggle_bit;
        tx_toggle_next = ~tx_toggle;
      end
      slow_phase_next = (slow_phase >= tbsm_pkg::PHASE_LAST) ? 4'd0 : slow_phase + 4'd1;
      fast_phase_next = 4'd0;
    end else begin
      fast_phase_next = fast_phase + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cs_err_run       <= 16'd0;
      id_mismatch_run  <= 16'd0;
      window_timer     <= 16'd0;
      window_errors    <= 16'd0;
      rate_value       <= 16'd0;
      fast_phase       <= 4'd0;
      slow_phase       <= 4'd0;
      tb_enabled       <= 1'b1;
      tb_last          <= 1'b0;
      tb_still_count   <= 16'd0;
      tb_hold_count    <= 16'd0;
      tx_toggle        <= 1'b0;
      restart_reg      <= 1'b0;
      reset_req_reg    <= 1'b0;
      alarm_reg        <= 1'b0;
      alarm_hold_count <= ALARM_HOLD;
    end else if (advance) begin
      cs_err_run       <= cs_err_run_next;
      id_mismatch_run  <= id_mismatch_run_next;
      window_timer     <= window_timer_next;
      window_errors    <= window_errors_next;
      rate_value       <= rate_value_next;
      fast_phase       <= fast_phase_next;
      slow_phase       <= slow_phase_next;
      tb_enabled       <= tb_enabled_next;
      tb_last          <= tb_last_next;
      tb_still_count   <= tb_still_count_next;
      tb_hold_count    <= tb_hold_count_next;
      tx_toggle        <= tx_toggle_next;
      restart_reg      <= restart_reg_next;
      reset_req_reg    <= reset_req_reg_next;
      alarm_reg        <= alarm_reg_next;
      alarm_hold_count <= alarm_hold_count_next;
    end
  end

  always_comb begin
    stat.alarm_now  = alarm_reg;
    stat.toggle_now = tx_toggle;
    stat.restart    = restart_reg_next;
    stat.reset_req  = reset_req_reg_next;
    stat.alarm      = alarm_reg_next;
    stat.rate       = rate_value_next;
  end

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the tdm basic slot monitor, with a frame scoreboard class
module testbench;

  localparam logic [15:0] ALARM_HOLD_VALUE = 16'd0;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [15:0] rx_word;
    logic        tx_dst_bit;
    logic [3:0]  tx_rate_bits;
    logic        warning_active;
    logic        alarm_active;
  } frame_in_t;

  typedef struct packed {
    logic [15:0] tx_word;
    logic        checksum_ok;
    logic        slot_ok;
    logic        rx_dst_valid;
    logic        rx_dst_bit;
    logic        restart_flag;
    logic        reset_request;
    logic        bus_alarm;
    logic [15:0] error_rate;
  } frame_result_t;

  typedef enum int {WORD_GOOD, WORD_BAD_SUM, WORD_BAD_ID, WORD_NOISE} word_kind_t;

  class slot_frame_scoreboard;
    tbsm_pkg::cfg_t regs;
    logic [15:0]   cs_run, id_run, win_timer, win_errors, rate_value;
    logic [15:0]   still_count, hold_count, alarm_hold;
    logic [3:0]    fast_phase, slow_phase;
    logic          tb_enabled, tb_last, tx_toggle, restart, reset_req, alarm;
    frame_result_t expected_frames[$];
    int            errors;

    function new();
      regs = '{4'd0, tbsm_pkg::RST_LIMIT, tbsm_pkg::RST_LIMIT, tbsm_pkg::RST_LIMIT,
               tbsm_pkg::RST_RATE_WINDOW, tbsm_pkg::RST_TOGGLE_TIMEOUT,
               tbsm_pkg::RST_TB_DISABLE, tbsm_pkg::RST_TB_HOLD_TIME};
      cs_run = '0; id_run = '0; win_timer = '0; win_errors = '0; rate_value = '0;
      still_count = '0; hold_count = '0; alarm_hold = ALARM_HOLD_VALUE;
      fast_phase = '0; slow_phase = '0;
      tb_enabled = 1'b1; tb_last = 1'b0; tx_toggle = 1'b0;
      restart = 1'b0; reset_req = 1'b0; alarm = 1'b0;
      errors = 0;
    endfunction

    static function logic [3:0] nibble_sum(logic [15:0] w);
      return 4'd1 + w[3:0] + w[7:4] + w[11:8];
    endfunction

    static function logic [15:0] bump(logic [15:0] v);
      return (v == tbsm_pkg::SAT_MAX) ? tbsm_pkg::SAT_MAX : v + 16'd1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        tbsm_pkg::CFG_SLOT_ID:        regs.slot_id = data[3:0];
        tbsm_pkg::CFG_MISMATCH_LIMIT: regs.mismatch_limit = data;
        tbsm_pkg::CFG_CS_ERROR_LIMIT: regs.cs_error_limit = data;
        tbsm_pkg::CFG_RATE_LIMIT:     regs.rate_limit = data;
        tbsm_pkg::CFG_RATE_WINDOW:    regs.rate_window = data;
        tbsm_pkg::CFG_TOGGLE_TIMEOUT: regs.toggle_timeout = data;
        tbsm_pkg::CFG_TB_DISABLE:     regs.tb_disable_threshold = data;
        tbsm_pkg::CFG_TB_HOLD_TIME:   regs.tb_hold_time = data;
        default: ;
      endcase
    endfunction

    function void predict_frame(frame_in_t f);
      logic          cs_ok, id_ok, rx_toggle;
      logic [15:0]   tx;
      frame_result_t r;
      cs_ok = (nibble_sum(f.rx_word) == f.rx_word[15:12]);
      cs_run = cs_ok ? 16'd0 : bump(cs_run);
      if (!cs_ok) win_errors = bump(win_errors);
      win_timer = win_timer + 16'd1;
      if (win_timer >= regs.rate_window) begin
        rate_value = win_errors;
        win_errors = '0;
        win_timer = '0;
      end
      id_ok = (f.rx_word[3:0] == regs.slot_id);
      id_run = id_ok ? 16'd0 : bump(id_run);

      tx = {4'd0, f.tx_rate_bits, f.alarm_active | alarm, f.warning_active,
            tx_toggle, f.tx_dst_bit, regs.slot_id};
      tx[15:12] = nibble_sum(tx);

      if (fast_phase == tbsm_pkg::PHASE_HEALTH) begin
        if (id_run > regs.mismatch_limit || cs_run > regs.cs_error_limit ||
            rate_value > regs.rate_limit) begin
          restart = 1'b1;
          alarm = 1'b1;
          alarm_hold = ALARM_HOLD_VALUE;
          tb_enabled = 1'b0;
          hold_count = regs.tb_hold_time;
        end
        if (alarm_hold != 16'd0) alarm_hold = alarm_hold - 16'd1;
        else alarm = 1'b0;
        if (cs_run > regs.tb_disable_threshold) begin
          tb_enabled = 1'b0;
          hold_count = regs.tb_hold_time;
        end else if (hold_count != 16'd0) begin
          hold_count = hold_count - 16'd1;
        end else begin
          tb_enabled = 1'b1;
        end
        fast_phase = tbsm_pkg::PHASE_HEALTH + 4'd1;
      end else if (fast_phase >= tbsm_pkg::PHASE_LAST) begin
        if (slow_phase == 4'd0) begin
          rx_toggle = f.rx_word[tbsm_pkg::BIT_TOGGLE];
          if (tb_enabled && tb_last == rx_toggle) begin
            still_count = bump(still_count);
            if (still_count > regs.toggle_timeout) reset_req = 1'b1;
          end else begin
            still_count = '0;
          end
          tb_last = rx_toggle;
          tx_toggle = ~tx_toggle;
        end
        slow_phase = (slow_phase >= tbsm_pkg::PHASE_LAST) ? 4'd0 : slow_phase + 4'd1;
        fast_phase = '0;
      end else begin
        fast_phase = fast_phase + 4'd1;
      end

      r.tx_word = tx;
      r.checksum_ok = cs_ok;
      r.slot_ok = id_ok;
      r.rx_dst_valid = cs_ok & id_ok;
      r.rx_dst_bit = f.rx_word[tbsm_pkg::BIT_DST];
      r.restart_flag = restart;
      r.reset_request = reset_req;
      r.bus_alarm = alarm;
      r.error_rate = rate_value;
      expected_frames.push_back(r);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %h, actual %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_frame(frame_result_t got);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      compare("tx_word", want.tx_word, got.tx_word);
      compare("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
      compare("slot_ok", 16'(want.slot_ok), 16'(got.slot_ok));
      compare("rx_dst_valid", 16'(want.rx_dst_valid), 16'(got.rx_dst_valid));
      compare("rx_dst_bit", 16'(want.rx_dst_bit), 16'(got.rx_dst_bit));
      compare("restart_flag", 16'(want.restart_flag), 16'(got.restart_flag));
      compare("reset_request", 16'(want.reset_request), 16'(got.reset_request));
      compare("bus_alarm", 16'(want.bus_alarm), 16'(got.bus_alarm));
      compare("error_rate", want.error_rate, got.error_rate);
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = tbsm_pkg::CFG_SLOT_ID;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] rx_word = 16'd0;
  logic        tx_dst_bit = 1'b0;
  logic [3:0]  tx_rate_bits = 4'd0;
  logic        warning_active = 1'b0;
  logic        alarm_active = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] tx_word;
  logic        checksum_ok, slot_ok, rx_dst_valid, rx_dst_bit;
  logic        restart_flag, reset_request, bus_alarm;
  logic [15:0] error_rate;

  slot_frame_scoreboard tracker;
  frame_result_t        seen_frame;
  int                   stall_pct = 0;
  int                   bad_sum_pct = 10;
  bit                   stuck_toggle = 1'b0;
  int                   cycle_count = 0;

  tdm_basic_slot_monitor #(.ALARM_HOLD(ALARM_HOLD_VALUE)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_word(rx_word), .tx_dst_bit(tx_dst_bit), .tx_rate_bits(tx_rate_bits),
    .warning_active(warning_active), .alarm_active(alarm_active),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_word(tx_word), .checksum_ok(checksum_ok), .slot_ok(slot_ok),
    .rx_dst_valid(rx_dst_valid), .rx_dst_bit(rx_dst_bit),
    .restart_flag(restart_flag), .reset_request(reset_request),
    .bus_alarm(bus_alarm), .error_rate(error_rate)
  );

  assign seen_frame = {tx_word, checksum_ok, slot_ok, rx_dst_valid, rx_dst_bit,
                       restart_flag, reset_request, bus_alarm, error_rate};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) tracker.check_frame(seen_frame);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [15:0] sound_word(logic [11:0] low);
    return {slot_frame_scoreboard::nibble_sum({4'd0, low}), low};
  endfunction

  function automatic frame_in_t make_frame(logic [3:0] slot);
    frame_in_t  f;
    word_kind_t kind;
    int         r;
    logic [11:0] low;
    r = $urandom_range(99);
    if (r < bad_sum_pct) kind = WORD_BAD_SUM;
    else if (r < bad_sum_pct + 10) kind = WORD_BAD_ID;
    else if (r < bad_sum_pct + 18) kind = WORD_NOISE;
    else kind = WORD_GOOD;
    low = 12'($urandom);
    low[3:0] = slot;
    if (stuck_toggle) low[tbsm_pkg::BIT_TOGGLE] = 1'b0;
    if (kind == WORD_BAD_ID) low[3:0] = slot ^ 4'($urandom_range(1, 15));
    f.rx_word = sound_word(low);
    if (kind == WORD_BAD_SUM) f.rx_word[15:12] ^= 4'($urandom_range(1, 15));
    if (kind == WORD_NOISE) f.rx_word = 16'($urandom);
    f.tx_dst_bit = 1'($urandom);
    f.tx_rate_bits = 4'($urandom);
    f.warning_active = 1'($urandom);
    f.alarm_active = 1'($urandom);
    return f;
  endfunction

  task automatic send_frame(frame_in_t f, int idle_pct, bit hold_off);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < idle_pct && gaps < 40) gaps++;
    if (gaps > 0 || (hold_off && tracker.pending() != 0)) begin
      in_valid <= 1'b0;
      while (hold_off && tracker.pending() != 0) @(posedge clk);
      repeat (gaps) @(posedge clk);
    end
    in_valid <= 1'b1;
    {rx_word, tx_dst_bit, tx_rate_bits, warning_active, alarm_active} <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.predict_frame(f);
  endtask

  task automatic run_phase(int count, int idle_pct, int pause_at);
    for (int i = 0; i < count; i++)
      send_frame(make_frame(tracker.regs.slot_id), idle_pct, i == pause_at);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(tbsm_pkg::cfg_t c);
    logic [15:0] vals [8];
    vals = '{{12'd0, c.slot_id}, c.mismatch_limit, c.cs_error_limit, c.rate_limit,
             c.rate_window, c.toggle_timeout, c.tb_disable_threshold, c.tb_hold_time};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      tracker.write_reg(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    frame_in_t f;
    tracker = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // field extremes under the reset settings
    send_frame('{16'h0000, 1'b0, 4'h0, 1'b0, 1'b0}, 0, 1'b0);
    send_frame('{16'hFFFF, 1'b1, 4'hF, 1'b1, 1'b1}, 0, 1'b0);
    send_frame('{sound_word(12'h000), 1'b0, 4'hF, 1'b0, 1'b1}, 0, 1'b0);
    send_frame('{sound_word(12'hFF0), 1'b1, 4'h0, 1'b1, 1'b0}, 0, 1'b0);
    send_frame('{sound_word(12'h001), 1'b0, 4'h5, 1'b0, 1'b0}, 0, 1'b0);
    send_frame('{sound_word(12'h010), 1'b1, 4'hA, 1'b0, 1'b0}, 0, 1'b0);
    send_frame('{sound_word(12'h020), 1'b0, 4'h3, 1'b1, 1'b0}, 0, 1'b0);
    send_frame('{sound_word(12'hFFF), 1'b1, 4'hC, 1'b0, 1'b1}, 0, 1'b0);
    send_frame('{16'h0010, 1'b0, 4'h9, 1'b0, 1'b0}, 0, 1'b0);
    for (int k = 0; k < 12; k++) begin
      f.rx_word = sound_word({8'($urandom), 4'd0});
      f.tx_dst_bit = k[0];
      f.warning_active = k[1];
      f.alarm_active = k[2];
      f.tx_rate_bits = 4'(k * 5);
      send_frame(f, 0, 1'b0);
    end
    in_valid <= 1'b0;
    drain();

    // no idling, widest limits, longest window
    stall_pct = 0;
    bad_sum_pct = 10;
    program_regs('{4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    run_phase(150, 0, -1);
    drain();

    // sender idles, window closes every frame, watchdog easily suspended
    stall_pct = 0;
    bad_sum_pct = 35;
    stuck_toggle = 1'b1;
    program_regs('{4'($urandom_range(15)), 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'd1,
                   16'd3, 16'd2});
    run_phase(150, 75, -1);
    drain();

    // receiver stalls, tight limits trip restart and toggle loss
    stall_pct = 75;
    bad_sum_pct = 25;
    program_regs('{4'd0, 16'd0, 16'd5, 16'd3, 16'd20, 16'd0, 16'hFFFF, 16'd0});
    run_phase(150, 0, -1);
    drain();

    // both sides idle, random settings, one pause until drained
    stall_pct = 38;
    bad_sum_pct = 20;
    stuck_toggle = 1'b0;
    program_regs('{4'($urandom_range(15)), 16'($urandom_range(0, 8)),
                   16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                   16'($urandom_range(1, 30)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 6)), 16'($urandom_range(0, 6))});
    run_phase(150, 38, 75);
    drain();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: tdm_basic_slot_monitor.f
design/tbsm_pkg.sv
design/tbsm_check.sv
design/tbsm_sched.sv
design/tdm_basic_slot_monitor.sv
tb/testbench.sv
